>>> rtl/heap_window_sorter_assert.svh
// ----------------------------------------------------------------------------
// heap_window_sorter assertion macros
// Shared property forms for the sorter checker.
// ----------------------------------------------------------------------------
`ifndef HEAP_WINDOW_SORTER_ASSERT_SVH
`define HEAP_WINDOW_SORTER_ASSERT_SVH

// same-cycle implication, reset-qualified
`define HWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define HWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hws_pkg.sv
// ----------------------------------------------------------------------------
// hws_pkg
// Types and constants shared by the heap window sorter.
// ----------------------------------------------------------------------------
package hws_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 63;

	typedef logic signed [DATA_W-1:0] hws_data_t;

	// operation applied to every cell of the row in the same cycle
	typedef struct packed {
		logic ins;
		logic shift;
	} hws_op_t;

endpackage

>>> rtl/hws_if.sv
// ----------------------------------------------------------------------------
// hws_in_if / hws_out_if
// Valid/ready channels for stream values and sorted results.
// ----------------------------------------------------------------------------
interface hws_in_if import hws_pkg::*; ();
	logic      valid;
	logic      ready;
	hws_data_t value;
	logic      final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink (input valid, input value, input final_item, output ready);
endinterface

interface hws_out_if import hws_pkg::*; ();
	logic      valid;
	logic      ready;
	hws_data_t sorted_value;
	logic      order_error;
	logic      end_of_run;

	modport source (output valid, output sorted_value, output order_error,
		output end_of_run, input ready);
	modport sink (input valid, input sorted_value, input order_error,
		input end_of_run, output ready);
endinterface

>>> rtl/heap_window_sorter.sv
// ----------------------------------------------------------------------------
// heap_window_sorter
// Replacement-selection sorter over a window of CAPACITY signed values.
// ----------------------------------------------------------------------------
// The window is a row of CAPACITY cells kept in ascending order; every cell
// sees the broadcast value and its two neighbors, and the whole row does one
// insert or one shift per cycle. While the window is not full a value is
// inserted in the cycle it is taken. Once full, an item is transferred, then
// the minimum is emitted and the row shifted when the result sink is free,
// then the item is inserted. An item with final_item set then drains the
// window at one result per cycle while the result sink does not stall, until
// every stored entry is emitted. end_of_run marks the last result of a drain;
// order_error flags a result below the previous one of the same stream.
module heap_window_sorter import hws_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hws_in_if.sink     feed,
	hws_out_if.source  result
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {S_IDLE, S_REPL, S_INS, S_DRAIN} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	hws_data_t      hold_value_q;
	logic           hold_final_q;
	hws_data_t      last_q;
	logic           emitted_any_q;
	logic           out_valid_q;
	hws_data_t      out_value_q;
	logic           out_error_q;
	logic           out_end_q;

	hws_data_t      cell_value [CAPACITY];
	logic           cell_valid [CAPACITY];
	logic           cell_keep  [CAPACITY];

	hws_op_t        op;
	hws_data_t      ins_value;
	logic           full;
	logic           out_free;
	logic           take;
	logic           emit;
	logic           emit_end;

	assign full      = (count_q == CW'(CAPACITY));
	assign out_free  = !out_valid_q || result.ready;
	assign feed.ready = (state_q == S_IDLE);
	assign take      = feed.valid && feed.ready;
	assign emit      = ((state_q == S_REPL) || (state_q == S_DRAIN)) && out_free;
	assign emit_end  = (state_q == S_DRAIN) && (count_q == CW'(1));
	assign ins_value = (state_q == S_IDLE) ? feed.value : hold_value_q;

	always_comb begin
		op.ins   = (take && !full) || (state_q == S_INS);
		op.shift = emit;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		hws_data_t l_value;
		logic      l_valid;
		logic      l_keep;
		hws_data_t r_value;
		logic      r_valid;

		if (i == 0) begin : g_first
			assign l_value = '0;
			assign l_valid = 1'b1;
			assign l_keep  = 1'b1;
		end else begin : g_mid
			assign l_value = cell_value[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_keep  = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_value = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_value = cell_value[i+1];
			assign r_valid = cell_valid[i+1];
		end

		hws_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.ins_value   (ins_value),
			.left_keep   (l_keep),
			.left_value  (l_value),
			.left_valid  (l_valid),
			.right_value (r_value),
			.right_valid (r_valid),
			.keep        (cell_keep[i]),
			.value       (cell_value[i]),
			.valid       (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			hold_final_q  <= 1'b0;
			last_q        <= '0;
			emitted_any_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_error_q   <= 1'b0;
			out_end_q     <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q   <= 1'b1;
				out_error_q   <= emitted_any_q && (cell_value[0] < last_q);
				out_end_q     <= emit_end;
				last_q        <= emit_end ? '0 : cell_value[0];
				emitted_any_q <= !emit_end;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						hold_final_q <= feed.final_item;
						if (full) begin
							state_q <= S_REPL;
						end else begin
							count_q <= count_q + CW'(1);
							state_q <= feed.final_item ? S_DRAIN : S_IDLE;
						end
					end
				end
				S_REPL: begin
					if (emit) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					state_q <= hold_final_q ? S_DRAIN : S_IDLE;
				end
				S_DRAIN: begin
					if (emit) begin
						count_q <= count_q - CW'(1);
						if (emit_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_value_q <= feed.value;
		end
		if (emit) begin
			out_value_q <= cell_value[0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_value_q;
	assign result.order_error  = out_error_q;
	assign result.end_of_run   = out_end_q;

endmodule

>>> rtl/hws_cell.sv
// ----------------------------------------------------------------------------
// hws_cell
// One slot of the sorted row: keeps its entry, takes the new value or the
// left neighbor on insert, takes the right neighbor on shift.
// ----------------------------------------------------------------------------
module hws_cell import hws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  hws_op_t   op,
	input  hws_data_t ins_value,
	input  logic      left_keep,
	input  hws_data_t left_value,
	input  logic      left_valid,
	input  hws_data_t right_value,
	input  logic      right_valid,
	output logic      keep,
	output hws_data_t value,
	output logic      valid
);

	hws_data_t value_q;
	logic      valid_q;

	assign keep  = valid_q && (value_q <= ins_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.shift) begin
			valid_q <= right_valid;
		end else if (op.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.shift) begin
			value_q <= right_value;
		end else if (op.ins && !keep) begin
			value_q <= left_keep ? ins_value : left_value;
		end
	end

endmodule

>>> rtl/hws_checker.sv
// ----------------------------------------------------------------------------
// hws_checker
// Port-level checks on the heap window sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "heap_window_sorter_assert.svh"

module hws_checker import hws_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      feed_valid,
	input logic      feed_ready,
	input logic      feed_final,
	input logic      res_valid,
	input logic      res_ready,
	input hws_data_t res_value,
	input logic      res_end
);

	// a stalled result holds its payload
	`HWS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value), "stalled result changed")

	// the final transfer starts a drain, no new value is taken right after
	`HWS_ASSERT_NEXT(a_final_blocks, feed_valid && feed_ready && feed_final, !feed_ready, "input taken during drain start")

	// a stalled result keeps its end-of-run mark
	`HWS_ASSERT_NEXT(a_end_stable, res_valid && !res_ready, $stable(res_end), "stalled end of run changed")

endmodule

bind heap_window_sorter hws_checker u_hws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.feed_valid (feed.valid),
	.feed_ready (feed.ready),
	.feed_final (feed.final_item),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_value  (result.sorted_value),
	.res_end    (result.end_of_run)
);

>>> tb/heap_window_sorter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_window_sorter_tb
// Drives value streams into the sorter with bursty input and a stalling
// result sink. A scoreboard keeps its own min-heap of the window, works out
// the emitted values, order flags and end-of-run marks for every accepted
// transfer, and compares each result transfer against the oldest one due.
// ----------------------------------------------------------------------------
module heap_window_sorter_tb;
	import hws_pkg::*;

	localparam int WINDOW = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 380;

	typedef struct packed {
		hws_data_t value;
		logic      order_error;
		logic      end_of_run;
	} sort_result_t;

	class sort_scoreboard;
		hws_data_t    heap[WINDOW];
		int           count = 0;
		hws_data_t    last_out = '0;
		bit           any_out = 1'b0;
		sort_result_t due_q[$];
		int           errors = 0;

		function void sift_up(int p);
			int up;
			hws_data_t t;
			while (p > 0) begin
				up = (p - 1) / 2;
				if (heap[up] <= heap[p])
					break;
				t = heap[up];
				heap[up] = heap[p];
				heap[p] = t;
				p = up;
			end
		endfunction

		function void sift_down(int p, int n);
			int lc;
			int rc;
			int best;
			hws_data_t t;
			while (p < n) begin
				lc = 2 * p + 1;
				rc = 2 * p + 2;
				best = p;
				if (lc < n && heap[lc] < heap[best])
					best = lc;
				if (rc < n && heap[rc] < heap[best])
					best = rc;
				if (best == p)
					break;
				t = heap[p];
				heap[p] = heap[best];
				heap[best] = t;
				p = best;
			end
		endfunction

		function void emit_min(hws_data_t v, bit eor);
			sort_result_t r;
			r.value = v;
			r.order_error = any_out && (v < last_out);
			r.end_of_run = eor;
			due_q.push_back(r);
			last_out = v;
			any_out = 1'b1;
		endfunction

		// one accepted input transfer
		function void note_input(hws_data_t v, bit fin);
			hws_data_t m;
			if (count < WINDOW) begin
				heap[count] = v;
				sift_up(count);
				count++;
			end else begin
				emit_min(heap[0], 1'b0);
				heap[0] = v;
				sift_down(0, count);
			end
			if (fin) begin
				while (count > 0) begin
					m = heap[0];
					count--;
					heap[0] = heap[count];
					sift_down(0, count);
					emit_min(m, count == 0);
				end
				last_out = '0;
				any_out = 1'b0;
			end
		endfunction

		function void check(hws_data_t v, logic err, logic eor);
			sort_result_t e;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d order_error=%b end_of_run=%b",
					$time, v, err, eor);
				errors++;
				return;
			end
			e = due_q.pop_front();
			if (v !== e.value) begin
				$display("%0t: sorted_value expected %0d actual %0d", $time, e.value, v);
				errors++;
			end
			if (err !== e.order_error) begin
				$display("%0t: order_error expected %b actual %b (value %0d)",
					$time, e.order_error, err, e.value);
				errors++;
			end
			if (eor !== e.end_of_run) begin
				$display("%0t: end_of_run expected %b actual %b (value %0d)",
					$time, e.end_of_run, eor, e.value);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hws_in_if  feed_if ();
	hws_out_if result_if ();

	heap_window_sorter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if),
		.result (result_if)
	);

	sort_scoreboard sb = new();

	int burst_left = 0;
	int stall_mode = 0;
	int stall_hold = 0;
	int stall_phase = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// input transfer first, so a same-edge result always finds its expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (feed_if.valid && feed_if.ready)
				sb.note_input(feed_if.value, feed_if.final_item);
			if (result_if.valid && result_if.ready)
				sb.check(result_if.sorted_value, result_if.order_error,
					result_if.end_of_run);
		end
	end

	// result sink: switches between free flow, light, periodic and heavy stall
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_hold <= $urandom_range(20, 200);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		stall_phase <= (stall_phase + 1) % 7;
		case (stall_mode)
			0: result_if.ready <= 1'b1;
			1: result_if.ready <= ($urandom_range(0, 3) != 0);
			2: result_if.ready <= (stall_phase < 4);
			default: result_if.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	task automatic idle(int n);
		feed_if.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(hws_data_t v, bit fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				idle(gap);
		end
		burst_left--;
		feed_if.valid <= 1'b1;
		feed_if.value <= v;
		feed_if.final_item <= fin;
		do
			@(posedge clk);
		while (!feed_if.ready);
	endtask

	function automatic hws_data_t pick_value(int mode, int idx, hws_data_t base);
		case (mode)
			0: return hws_data_t'($urandom);
			1: return hws_data_t'($urandom_range(0, 15)) - 8;
			2: begin
				case ($urandom_range(0, 5))
					0: return {1'b1, {(DATA_W-1){1'b0}}};
					1: return {1'b0, {(DATA_W-1){1'b1}}};
					2: return '0;
					3: return '1;
					4: return 1;
					default: return hws_data_t'($urandom);
				endcase
			end
			default: return base - hws_data_t'(idx * 1000) + hws_data_t'($urandom_range(0, 1500));
		endcase
	endfunction

	initial begin
		hws_data_t base;
		int sent;
		int len;
		int mode;
		int r;

		arst_n = 1'b0;
		feed_if.valid = 1'b0;
		feed_if.value = '0;
		feed_if.final_item = 1'b0;
		result_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-value streams at both ends of the range
		send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
		send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
		// mixed extremes with duplicates, drained from a partly filled window
		send_item('0, 1'b0);
		send_item('1, 1'b0);
		send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
		send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
		send_item(7, 1'b0);
		send_item(7, 1'b0);
		send_item(-5, 1'b1);
		// all-equal stream
		send_item(3, 1'b0);
		send_item(3, 1'b0);
		send_item(3, 1'b0);
		send_item(3, 1'b1);
		// alternating bit patterns
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(32'h0000_0001, 1'b1);

		// random streams: short, around the window size, and well past it
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				len = $urandom_range(1, 8);
			else if (r < 5)
				len = $urandom_range(WINDOW - 2, WINDOW + 3);
			else
				len = $urandom_range(WINDOW + 1, 2 * WINDOW + 14);
			mode = $urandom_range(0, 4);
			base = hws_data_t'($urandom);
			for (int k = 0; k < len; k++)
				send_item(pick_value(mode, k, base), k == len - 1);
			sent += len;
		end
		idle(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
